// ----- hdl/tpm_pkg.sv -----
`timescale 1ns / 1ps

package tpm_pkg;

  // Default network size
  localparam int SLAVE_COUNT_DEF = 32;

  // Default queue depths
  localparam int CMD_DEPTH_DEF = 4;
  localparam int RES_DEPTH_DEF = 4;

  // Field widths
  localparam int OPCODE_W  = 3;
  localparam int ADDR_W    = 5;
  localparam int REPLY_W   = 8;
  localparam int NIBBLE_W  = 4;
  localparam int FRAME_W   = 14;
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int WAIT_W    = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AVAILABLE_MASK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPLY_TIMEOUT  = 1'd1;

  // Reset values of the configuration registers, and the wait counter ceiling
  localparam logic [CFG_DATA_W-1:0] AVAILABLE_MASK_RST = 32'h0000_0001;
  localparam logic [WAIT_W-1:0]     REPLY_TIMEOUT_RST  = 16'd100;
  localparam logic [WAIT_W-1:0]     WAIT_MAX           = 16'hFFFF;

  // Input opcodes
  localparam logic [OPCODE_W-1:0] OP_TICK   = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_REPLY  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_ERASE  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_ASSIGN = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_WRITE  = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_READ   = 3'd5;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_FRAME  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CYCLE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_INPUTS = 2'd2;
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd3;

  // Request status codes
  localparam logic [STATUS_W-1:0] ST_ACCEPTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_IN_USE   = 2'd3;

  typedef enum logic [1:0] {
    PH_TRANSMIT  = 2'd0,
    PH_WAIT      = 2'd1,
    PH_NEXT      = 2'd2,
    PH_CYCLE_END = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    CL_TICK   = 3'd0,
    CL_REPLY  = 3'd1,
    CL_ERASE  = 3'd2,
    CL_ASSIGN = 3'd3,
    CL_WRITE  = 3'd4,
    CL_READ   = 3'd5
  } cmd_class_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [ADDR_W-1:0]   address;
    logic [REPLY_W-1:0]  reply_byte;
    logic [NIBBLE_W-1:0] output_bits;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]   result_kind;
    logic [FRAME_W-1:0]  frame_word;
    logic [ADDR_W-1:0]   polled_slave;
    logic [NIBBLE_W-1:0] input_bits;
    logic [STATUS_W-1:0] status_code;
  } out_item_t;

  // Decoded command handed from the front end to the executor
  typedef struct packed {
    cmd_class_t          cls;
    logic [ADDR_W-1:0]   address;
    logic                addr_in;   // address below the slave count
    logic                addr_ok;   // address in 1..slave count - 1
    logic [NIBBLE_W-1:0] reply_bits;
    logic                reply_ok;  // reply parity matches
    logic [NIBBLE_W-1:0] output_bits;
  } cmd_t;

  // Start 0, command, address, data, even parity over bits 0..11, end 1
  function automatic logic [FRAME_W-1:0] build_frame(input logic cmd,
                                                     input logic [ADDR_W-1:0] addr,
                                                     input logic [ADDR_W-1:0] data);
    logic [11:0] body;
    body = {data, addr, cmd, 1'b0};
    return {1'b1, ^body, body};
  endfunction

endpackage

// ----- hdl/tpm_fifo.sv -----
`timescale 1ns / 1ps

module tpm_fifo #(
  parameter int  DEPTH = 4,
  parameter type T     = logic
) (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  T     wr_data,
  output logic wr_ready,
  input  logic rd,
  output logic rd_valid,
  output T     rd_data
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW:0] FULL_CNT = (AW + 1)'(DEPTH);

  T            mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          do_wr;
  logic          do_rd;

  // A beat may enter a full queue when the head leaves in the same cycle
  assign rd_valid = (count != '0);
  assign wr_ready = (count != FULL_CNT) || rd;
  assign do_rd    = rd && rd_valid;
  assign do_wr    = wr && wr_ready;
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- hdl/tpm_front.sv -----
`timescale 1ns / 1ps

module tpm_front #(
  parameter int SLAVE_COUNT = tpm_pkg::SLAVE_COUNT_DEF
) (
  input  tpm_pkg::in_item_t item,
  output tpm_pkg::cmd_t     cmd,
  output logic              keep
);

  // Classify the beat; drop opcodes with no meaning
  always_comb begin
    cmd.address     = item.address;
    cmd.addr_in     = (32'(item.address) < SLAVE_COUNT);
    cmd.addr_ok     = cmd.addr_in && (item.address != '0);
    cmd.reply_bits  = item.reply_byte[4:1];
    cmd.reply_ok    = (^item.reply_byte[4:0]) == item.reply_byte[5];
    cmd.output_bits = item.output_bits;
    cmd.cls         = tpm_pkg::CL_TICK;
    keep            = 1'b1;
    unique case (item.opcode)
      tpm_pkg::OP_TICK:   cmd.cls = tpm_pkg::CL_TICK;
      tpm_pkg::OP_REPLY:  cmd.cls = tpm_pkg::CL_REPLY;
      tpm_pkg::OP_ERASE:  cmd.cls = tpm_pkg::CL_ERASE;
      tpm_pkg::OP_ASSIGN: cmd.cls = tpm_pkg::CL_ASSIGN;
      tpm_pkg::OP_WRITE:  cmd.cls = tpm_pkg::CL_WRITE;
      tpm_pkg::OP_READ:   cmd.cls = tpm_pkg::CL_READ;
      default:            keep    = 1'b0;
    endcase
  end

endmodule

// ----- hdl/tpm_back.sv -----
`timescale 1ns / 1ps

module tpm_back #(
  parameter int SLAVE_COUNT = tpm_pkg::SLAVE_COUNT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_en,
  input  logic [tpm_pkg::CFG_IDX_W-1:0]        wr_index,
  input  logic [tpm_pkg::CFG_DATA_W-1:0]       wr_data,
  input  logic                                 cmd_valid,
  input  tpm_pkg::cmd_t                        cmd,
  output logic                                 cmd_take,
  input  logic                                 res_ready,
  output logic                                 res_push,
  output tpm_pkg::out_item_t                   res
);

  localparam int IW = $clog2(SLAVE_COUNT);

  // Configuration
  logic [tpm_pkg::CFG_DATA_W-1:0] avail_mask;
  logic [tpm_pkg::WAIT_W-1:0]     reply_timeout;

  // Schedule state
  tpm_pkg::phase_t             phase, phase_next;
  logic [IW-1:0]               current_slave, current_slave_next;
  logic [tpm_pkg::WAIT_W-1:0]  wait_count, wait_count_next;
  logic [SLAVE_COUNT-1:0]      erase_pending, erase_pending_next;
  logic                        assign_pending, assign_pending_next;
  logic [tpm_pkg::ADDR_W-1:0]  assign_address, assign_address_next;

  logic [tpm_pkg::NIBBLE_W-1:0] slave_outputs [SLAVE_COUNT];
  logic [tpm_pkg::NIBBLE_W-1:0] slave_inputs  [SLAVE_COUNT];

  logic                        out_we;
  logic                        in_we;
  logic [IW-1:0]               addr_idx;
  logic [SLAVE_COUNT-1:0]      present;
  logic                        addr_present;
  logic [tpm_pkg::WAIT_W-1:0]  wait_inc;
  logic                        found_hi;
  logic                        found_any;
  logic [IW-1:0]               slave_hi;
  logic [IW-1:0]               slave_any;
  logic [IW-1:0]               slave_found;

  assign cmd_take     = cmd_valid && res_ready;
  assign addr_idx     = cmd.address[IW-1:0];
  assign present      = avail_mask[SLAVE_COUNT-1:0];
  assign addr_present = cmd.addr_in && present[addr_idx];
  assign wait_inc     = (wait_count != tpm_pkg::WAIT_MAX) ? wait_count + 1'b1 : wait_count;

  // Round-robin search: lowest present slave above the current one, else
  // the lowest present slave at all, else stay put
  always_comb begin
    found_hi  = 1'b0;
    found_any = 1'b0;
    slave_hi  = '0;
    slave_any = '0;
    for (int i = SLAVE_COUNT - 1; i >= 0; i--) begin
      if (present[i]) begin
        found_any = 1'b1;
        slave_any = IW'(i);
        if (IW'(i) > current_slave) begin
          found_hi = 1'b1;
          slave_hi = IW'(i);
        end
      end
    end
    if (found_hi) begin
      slave_found = slave_hi;
    end else if (found_any) begin
      slave_found = slave_any;
    end else begin
      slave_found = current_slave;
    end
  end

  always_comb begin
    phase_next          = phase;
    current_slave_next  = current_slave;
    wait_count_next     = wait_count;
    erase_pending_next  = erase_pending;
    assign_pending_next = assign_pending;
    assign_address_next = assign_address;
    out_we              = 1'b0;
    in_we               = 1'b0;
    res_push            = 1'b0;
    res                 = '0;
    res.polled_slave    = cmd.address;
    if (cmd_take) begin
      unique case (cmd.cls)
        tpm_pkg::CL_TICK: begin
          res.polled_slave = tpm_pkg::ADDR_W'(current_slave);
          unique case (phase)
            tpm_pkg::PH_TRANSMIT: begin
              res_push         = 1'b1;
              res.result_kind  = tpm_pkg::KIND_FRAME;
              if (current_slave != '0 && erase_pending[current_slave]) begin
                res.frame_word = tpm_pkg::build_frame(1'b1,
                                   tpm_pkg::ADDR_W'(current_slave), '0);
                erase_pending_next[current_slave] = 1'b0;
              end else if (current_slave == '0 && assign_pending) begin
                res.frame_word = tpm_pkg::build_frame(1'b0, '0, assign_address);
                assign_pending_next = 1'b0;
              end else begin
                res.frame_word = tpm_pkg::build_frame(1'b0,
                                   tpm_pkg::ADDR_W'(current_slave),
                                   {slave_outputs[current_slave], 1'b0});
              end
              wait_count_next = '0;
              phase_next      = tpm_pkg::PH_WAIT;
            end
            tpm_pkg::PH_WAIT: begin
              wait_count_next = wait_inc;
              if (wait_inc >= reply_timeout) begin
                phase_next = tpm_pkg::PH_NEXT;
              end
            end
            tpm_pkg::PH_NEXT: begin
              current_slave_next = slave_found;
              phase_next = (slave_found <= current_slave) ? tpm_pkg::PH_CYCLE_END
                                                          : tpm_pkg::PH_TRANSMIT;
            end
            tpm_pkg::PH_CYCLE_END: begin
              res_push        = 1'b1;
              res.result_kind = tpm_pkg::KIND_CYCLE;
              phase_next      = tpm_pkg::PH_TRANSMIT;
            end
            default: phase_next = phase;
          endcase
        end
        tpm_pkg::CL_REPLY: begin
          if (phase == tpm_pkg::PH_WAIT) begin
            in_we      = cmd.reply_ok;
            phase_next = tpm_pkg::PH_NEXT;
          end
        end
        tpm_pkg::CL_ERASE: begin
          res_push        = 1'b1;
          res.result_kind = tpm_pkg::KIND_STATUS;
          if (!cmd.addr_ok) begin
            res.status_code = tpm_pkg::ST_RANGE;
          end else if (!addr_present) begin
            res.status_code = tpm_pkg::ST_ABSENT;
          end else begin
            res.status_code = tpm_pkg::ST_ACCEPTED;
            erase_pending_next[addr_idx] = 1'b1;
          end
        end
        tpm_pkg::CL_ASSIGN: begin
          res_push        = 1'b1;
          res.result_kind = tpm_pkg::KIND_STATUS;
          if (!cmd.addr_ok) begin
            res.status_code = tpm_pkg::ST_RANGE;
          end else if (addr_present) begin
            res.status_code = tpm_pkg::ST_IN_USE;
          end else begin
            res.status_code     = tpm_pkg::ST_ACCEPTED;
            assign_pending_next = 1'b1;
            assign_address_next = cmd.address;
          end
        end
        tpm_pkg::CL_WRITE: begin
          out_we = cmd.addr_in;
        end
        tpm_pkg::CL_READ: begin
          res_push        = 1'b1;
          res.result_kind = tpm_pkg::KIND_INPUTS;
          res.input_bits  = cmd.addr_in ? slave_inputs[addr_idx] : '0;
        end
        default: res_push = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avail_mask    <= tpm_pkg::AVAILABLE_MASK_RST;
      reply_timeout <= tpm_pkg::REPLY_TIMEOUT_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        tpm_pkg::REG_AVAILABLE_MASK: avail_mask    <= wr_data;
        tpm_pkg::REG_REPLY_TIMEOUT:  reply_timeout <= wr_data[tpm_pkg::WAIT_W-1:0];
        default:                     avail_mask    <= avail_mask;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= tpm_pkg::PH_TRANSMIT;
      current_slave  <= '0;
      wait_count     <= '0;
      erase_pending  <= '0;
      assign_pending <= 1'b0;
      assign_address <= '0;
    end else begin
      phase          <= phase_next;
      current_slave  <= current_slave_next;
      wait_count     <= wait_count_next;
      erase_pending  <= erase_pending_next;
      assign_pending <= assign_pending_next;
      assign_address <= assign_address_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLAVE_COUNT; i++) begin
        slave_outputs[i] <= '0;
        slave_inputs[i]  <= '0;
      end
    end else begin
      if (out_we) begin
        slave_outputs[addr_idx] <= cmd.output_bits;
      end
      if (in_we) begin
        slave_inputs[current_slave] <= cmd.reply_bits;
      end
    end
  end

endmodule

// ----- hdl/tdma_polling_master_unit.sv -----
`timescale 1ns / 1ps
// Flow: an item leaves the input queue only after its push is registered there,
//   and its result shows on the result side once it is registered in the result queue.
// Throughput: one item per cycle while the result queue has room; the executor and
//   both 4-beat queues keep that pace, and only a full result queue slows intake.
// Reset (rst, synchronous): both queues empty, schedule in transmit phase at
//   slave 0, pending commands and all slave I/O cleared, registers at defaults.

module tdma_polling_master_unit #(
  parameter int SLAVE_COUNT = tpm_pkg::SLAVE_COUNT_DEF,
  parameter int CMD_DEPTH   = tpm_pkg::CMD_DEPTH_DEF,
  parameter int RES_DEPTH   = tpm_pkg::RES_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration write port
  input  logic                           wr_en,
  input  logic [tpm_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [tpm_pkg::CFG_DATA_W-1:0] wr_data,
  // Input queue side
  input  logic                           push,
  output logic                           full,
  input  tpm_pkg::in_item_t              item,
  // Result queue side
  output logic                           empty,
  input  logic                           pop,
  output tpm_pkg::out_item_t             result
);

  tpm_pkg::cmd_t      dec_cmd;
  logic               dec_keep;
  logic               cmd_ready;
  logic               cmd_valid;
  tpm_pkg::cmd_t      cmd_head;
  logic               cmd_take;
  logic               res_ready;
  logic               res_push;
  tpm_pkg::out_item_t res_item;
  logic               res_valid;

  // Front end: decode the beat, drop meaningless opcodes before queuing
  tpm_front #(
    .SLAVE_COUNT (SLAVE_COUNT)
  ) u_front (
    .item (item),
    .cmd  (dec_cmd),
    .keep (dec_keep)
  );

  // Command queue: lets intake run ahead of the executor
  tpm_fifo #(
    .DEPTH (CMD_DEPTH),
    .T     (tpm_pkg::cmd_t)
  ) u_cmd_q (
    .clk      (clk),
    .rst      (rst),
    .wr       (push && dec_keep),
    .wr_data  (dec_cmd),
    .wr_ready (cmd_ready),
    .rd       (cmd_take),
    .rd_valid (cmd_valid),
    .rd_data  (cmd_head)
  );

  assign full = !cmd_ready;

  // Back end: run the polling schedule and host requests, one command a cycle;
  // hold the head command while the result queue has no room
  tpm_back #(
    .SLAVE_COUNT (SLAVE_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd_head),
    .cmd_take  (cmd_take),
    .res_ready (res_ready),
    .res_push  (res_push),
    .res       (res_item)
  );

  // Result queue: parts the executor from the consumer's pop
  tpm_fifo #(
    .DEPTH (RES_DEPTH),
    .T     (tpm_pkg::out_item_t)
  ) u_res_q (
    .clk      (clk),
    .rst      (rst),
    .wr       (res_push),
    .wr_data  (res_item),
    .wr_ready (res_ready),
    .rd       (pop),
    .rd_valid (res_valid),
    .rd_data  (result)
  );

  assign empty = !res_valid;

endmodule
